[sv/rotary_position_embedding_unit_defines.svh]
// Assertion macros shared by the rotary position embedding unit modules.
`ifndef ROTARY_POSITION_EMBEDDING_UNIT_DEFINES_SVH
`define ROTARY_POSITION_EMBEDDING_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RPE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rpe assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RPE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rpe assertion failed");

`endif

[sv/rpe_pkg.sv]
// Package with constants, tables and types of the rotary position embedding unit.
package rpe_pkg;

  localparam int HEAD_SIZE    = 128;
  localparam int ROTATED_SIZE = 96;
  localparam int QUERY_HEADS  = 24;
  localparam int FREQ_BASE    = 10000;

  localparam int HALF_ROT     = ROTATED_SIZE / 2;
  localparam int CORDIC_STEPS = 30;
  localparam int ROM_DEPTH    = 64;  // one entry for every pair index code

  localparam logic [63:0] LN2_Q62    = 64'h2C5C85FDF473DE6B;
  localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  typedef logic [31:0] rom_arr_t  [ROM_DEPTH];
  typedef logic [31:0] atan_arr_t [CORDIC_STEPS];

  typedef struct packed {
    logic               key;
    logic [4:0]         head;
    logic [5:0]         pair;
    logic               rot;
    logic [1:0]         quad;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } rpe_tag_t;

  function automatic logic [63:0] mul_shr(logic [63:0] x, logic [63:0] y, int s);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    p = p >> s;
    return p[63:0];
  endfunction

  // log2(FREQ_BASE) in Q8.56, one squaring per result bit.
  function automatic logic [63:0] log2_base();
    logic [63:0] base;
    logic [63:0] y;
    logic [63:0] lg;
    int n;
    base = 64'(FREQ_BASE);
    n = 0;
    while (n < 62 && (base >> (n + 1)) != 64'd0) n++;
    y = base << (62 - n);
    lg = 64'(n) << 56;
    for (int k = 1; k <= 56; k++) begin
      y = mul_shr(y, y, 62);
      if (y >= 64'h8000000000000000) begin
        lg = lg | (64'd1 << (56 - k));
        y = y >> 1;
      end
    end
    return lg;
  endfunction

  function automatic rom_arr_t build_rom();
    rom_arr_t rom;
    logic [63:0] q, t, ti, tf, x, e, term, f, s;
    q = (64'd2 * log2_base()) / 64'(ROTATED_SIZE);
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = 32'd0;
      if (i < HALF_ROT) begin
        t = q * 64'(i);
        ti = t >> 56;
        tf = t & ((64'd1 << 56) - 64'd1);
        x = mul_shr(tf, LN2_Q62, 56);
        e = 64'd1 << 62;
        term = 64'd1 << 62;
        for (int k = 1; k < 48; k++) begin
          if (term != 64'd0) begin
            term = mul_shr(term, x, 62) / 64'(k);
            if ((k & 1) != 0) e = e - term;
            else e = e + term;
          end
        end
        f = mul_shr(e, INV2PI_Q64, 64);
        s = 64'd30 + ti;
        if (s < 64'd63) rom[i] = 32'((f + (64'd1 << (s - 64'd1))) >> s);
      end
    end
    return rom;
  endfunction

  function automatic atan_arr_t build_atan();
    atan_arr_t tab;
    logic [63:0] p, x2, sum, term, t;
    tab[0] = 32'h20000000;
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      p = 64'd1 << (62 - k);
      x2 = mul_shr(p, p, 62);
      sum = 64'd0;
      for (int m = 0; m < 40; m++) begin
        if (p != 64'd0) begin
          term = p / 64'(2 * m + 1);
          if ((m & 1) != 0) sum = sum - term;
          else sum = sum + term;
          p = mul_shr(p, x2, 62);
        end
      end
      t = mul_shr(sum, INV2PI_Q64, 64);
      tab[k] = 32'((t + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam rom_arr_t  FREQ_ROM  = build_rom();
  localparam atan_arr_t ATAN_TAB  = build_atan();

endpackage

[sv/rpe_phase.sv]
// Phase generation: frequency lookup, position multiply and quadrant split.
`include "rotary_position_embedding_unit_defines.svh"
module rpe_phase (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  rpe_pkg::rpe_tag_t       tag_i,
  input  logic [16:0]             position_i,
  output logic                    valid_o,
  output rpe_pkg::rpe_tag_t       tag_o,
  output logic signed [32:0]      z_o
);
  import rpe_pkg::*;

  logic              v1_q, v2_q;
  rpe_tag_t          t1_q, t1_d, t2_q, t2_d;
  logic [31:0]       phase_q;
  logic [48:0]       prod;
  logic [31:0]       u;
  logic signed [32:0] z_q, z_d;

  always_comb begin
    prod = position_i * FREQ_ROM[tag_i.pair];
    t1_d = tag_i;
    t1_d.rot = (32'(tag_i.pair) < 32'(HALF_ROT));
    u = phase_q + 32'h20000000;
    t2_d = t1_q;
    t2_d.quad = u[31:30];
    z_d = $signed({3'b000, u[29:0]}) - 33'sh020000000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q    <= t1_d;
      phase_q <= prod[31:0];
      t2_q    <= t2_d;
      z_q     <= z_d;
    end
  end

  assign valid_o = v2_q;
  assign tag_o   = t2_q;
  assign z_o     = z_q;

  `RPE_ASSERT_NEXT(a_pass_flag, clk_i, rst_ni,
    en_i && valid_i && (32'(tag_i.pair) >= 32'(HALF_ROT)), !t1_q.rot)
endmodule

[sv/rpe_cordic.sv]
// Pipelined CORDIC in rotation mode, one iteration per register stage.
`include "rotary_position_embedding_unit_defines.svh"
module rpe_cordic (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  rpe_pkg::rpe_tag_t       tag_i,
  input  logic signed [32:0]      z_i,
  output logic                    valid_o,
  output rpe_pkg::rpe_tag_t       tag_o,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);
  import rpe_pkg::*;

  logic               v_q [CORDIC_STEPS];
  rpe_tag_t           t_q [CORDIC_STEPS];
  logic signed [33:0] x_q [CORDIC_STEPS];
  logic signed [33:0] y_q [CORDIC_STEPS];
  logic signed [32:0] z_q [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic               v_in;
    rpe_tag_t           t_in;
    logic signed [33:0] x_in, y_in;
    logic signed [32:0] z_in;
    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign t_in = tag_i;
      assign x_in = CORDIC_GAIN;
      assign y_in = 34'sd0;
      assign z_in = z_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign t_in = t_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[k] <= t_in;
        if (!z_in[32]) begin
          x_q[k] <= x_in - (y_in >>> k);
          y_q[k] <= y_in + (x_in >>> k);
          z_q[k] <= z_in - $signed({1'b0, ATAN_TAB[k]});
        end else begin
          x_q[k] <= x_in + (y_in >>> k);
          y_q[k] <= y_in - (x_in >>> k);
          z_q[k] <= z_in + $signed({1'b0, ATAN_TAB[k]});
        end
      end
    end
  end

  assign valid_o = v_q[CORDIC_STEPS-1];
  assign tag_o   = t_q[CORDIC_STEPS-1];
  assign cos_o   = x_q[CORDIC_STEPS-1];
  assign sin_o   = y_q[CORDIC_STEPS-1];

  `RPE_ASSERT_NEXT(a_first_valid, clk_i, rst_ni, en_i, v_q[0] == $past(valid_i))
endmodule

[sv/rpe_rotate.sv]
// Quadrant mapping, element products, rounding and saturation.
`include "rotary_position_embedding_unit_defines.svh"
module rpe_rotate (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  rpe_pkg::rpe_tag_t       tag_i,
  input  logic signed [33:0]      cos_i,
  input  logic signed [33:0]      sin_i,
  output logic                    valid_o,
  output rpe_pkg::rpe_tag_t       tag_o,
  output logic signed [31:0]      first_o,
  output logic signed [31:0]      second_o
);
  import rpe_pkg::*;

  logic               vm_q, vo_q;
  rpe_tag_t           tm_q, to_q;
  logic signed [33:0] c, s;
  logic signed [65:0] ac_q, bs_q, bc_q, as_q;
  logic signed [31:0] f_q, f_d, g_q, g_d;

  function automatic logic signed [31:0] round_sat(logic signed [66:0] acc);
    logic signed [66:0] r;
    r = (acc + 67'sd536870912) >>> 30;
    if (r > 67'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -67'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  always_comb begin
    case (tag_i.quad)
      2'd0:    begin c = cos_i;  s = sin_i;  end
      2'd1:    begin c = -sin_i; s = cos_i;  end
      2'd2:    begin c = -cos_i; s = -sin_i; end
      default: begin c = sin_i;  s = -cos_i; end
    endcase
    if (tm_q.rot) begin
      f_d = round_sat(67'(ac_q) - 67'(bs_q));
      g_d = round_sat(67'(bc_q) + 67'(as_q));
    end else begin
      f_d = tm_q.a;
      g_d = tm_q.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      vm_q <= valid_i;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tm_q <= tag_i;
      ac_q <= tag_i.a * c;
      bs_q <= tag_i.b * s;
      bc_q <= tag_i.b * c;
      as_q <= tag_i.a * s;
      to_q <= tm_q;
      f_q  <= f_d;
      g_q  <= g_d;
    end
  end

  assign valid_o  = vo_q;
  assign tag_o    = to_q;
  assign first_o  = f_q;
  assign second_o = g_q;

  `RPE_ASSERT_NEXT(a_pass_copy, clk_i, rst_ni,
    en_i && vm_q && !tm_q.rot, (f_q == $past(tm_q.a)) && (g_q == $past(tm_q.b)))
endmodule

[sv/rotary_position_embedding_unit.sv]
// Top level of the rotary position embedding unit.
//
//   Channel   Handshake                  Payload
//   cfg       cfg_valid_i / cfg_ready_o  cfg_data_i (token position, 17 bits)
//   in        in_valid_i / in_ready_o    is_key_head, head_number, pair_number, elements
//   out       out_valid_o / out_ready_i  tags, first_rotated, second_rotated
//
// One word enters per cycle when the output is not stalled. The path has 34
// register stages: two phase stages, thirty CORDIC iterations and two rotate
// stages, the last of which is the output register. All stages move together.
// Reset clears the valid bit of every stage and sets the token position to zero.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
// Bubbles already inside stay where they are until the output word is taken.
module rotary_position_embedding_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               is_key_head_i,
  input  logic [4:0]         head_number_i,
  input  logic [5:0]         pair_number_i,
  input  logic signed [31:0] first_element_i,
  input  logic signed [31:0] second_element_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               key_head_tag_o,
  output logic [4:0]         head_tag_o,
  output logic [5:0]         pair_tag_o,
  output logic signed [31:0] first_rotated_o,
  output logic signed [31:0] second_rotated_o
);
  import rpe_pkg::*;

  logic [16:0]        position_q;
  logic               en;
  rpe_tag_t           tag_in, tag_ph, tag_cd, tag_out;
  logic               v_ph, v_cd;
  logic signed [32:0] z_ph;
  logic signed [33:0] cos_cd, sin_cd;

  // The pipeline advances whenever the output register is empty or being taken.
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= 17'd0;
    end else if (cfg_valid_i) begin
      position_q <= cfg_data_i;
    end
  end

  always_comb begin
    tag_in.key  = is_key_head_i;
    tag_in.head = head_number_i;
    tag_in.pair = pair_number_i;
    tag_in.rot  = 1'b0;
    tag_in.quad = 2'd0;
    tag_in.a    = first_element_i;
    tag_in.b    = second_element_i;
  end

  rpe_phase u_phase (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .tag_i(tag_in),
    .position_i(position_q), .valid_o(v_ph), .tag_o(tag_ph), .z_o(z_ph)
  );

  rpe_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_ph), .tag_i(tag_ph), .z_i(z_ph),
    .valid_o(v_cd), .tag_o(tag_cd), .cos_o(cos_cd), .sin_o(sin_cd)
  );

  rpe_rotate u_rotate (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_cd), .tag_i(tag_cd),
    .cos_i(cos_cd), .sin_i(sin_cd), .valid_o(out_valid_o), .tag_o(tag_out),
    .first_o(first_rotated_o), .second_o(second_rotated_o)
  );

  assign key_head_tag_o = tag_out.key;
  assign head_tag_o     = tag_out.head;
  assign pair_tag_o     = tag_out.pair;
endmodule
